/* rtl/dcrm_pkg.sv */
// Shared types and constants for the decaying rate meter.
package dcrm_pkg;

  // Input beat: one metering event
  typedef struct packed {
    logic        kind;
    logic [31:0] amount;
    logic [31:0] seconds;
    logic [19:0] microseconds;
  } dcrm_in_t;

  // Result beat: scaled rate and running total
  typedef struct packed {
    logic [31:0] rate_per_second;
    logic [63:0] grand_total;
  } dcrm_out_t;

  // Event kinds
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Ticks of history before the rate is simply replaced
  localparam logic [31:0] HISTORY_TICKS = 32'd166;
  // Above this the per-second scaling divides before multiplying
  localparam logic [31:0] RATE_BIG      = 32'h0FFF_FFFF;
  // Microseconds per second, for the fractional tick
  localparam logic [22:0] US_PER_SECOND = 23'd1000000;
  localparam int          TICKS_PER_SEC = 7;

endpackage

/* rtl/decaying_rate_meter.sv */
// Top level of the decaying rate meter: sequencer around one shared adder.
//
// Usage: each input beat (in_valid/in_ready, payload in_data) carries a time
// stamp and an amount. The stamp is turned into a tick count at seven ticks
// per second. A count beat adds its amount to a 64-bit total; a read beat
// counts zero. The decayed rate is multiplied by 7/8 once per elapsed tick
// (up to 166 ticks), or replaced outright when more time has passed, and
// then the amount is added. Each input beat yields exactly one result beat
// (out_valid/out_ready, payload out_data) with the rate per second and the
// grand total.
// Sequence: after acceptance the sequencer steps through SEC7, US7, NOW and
// ELAP, then through DEC and ADD unless the rate is replaced, then SCALE; the
// next beat waits until SCALE hands off its result. Decay steps run one per
// cycle through the single 32-bit add/subtract unit, which also forms the
// tick count and per-second scaling. in_ready is high only while idle.
// The result sits in an output register, so a new beat is accepted while the
// last result is still waiting; if the receiver stalls, the sequencer holds
// the next finished result until the output register frees up.
// Reset (rst_n low, synchronous) clears the total, rate and last tick to zero
// and empties the output register.
module decaying_rate_meter
  import dcrm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dcrm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output dcrm_out_t out_data
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEC7  = 3'd1;
  localparam logic [2:0] S_US7   = 3'd2;
  localparam logic [2:0] S_NOW   = 3'd3;
  localparam logic [2:0] S_ELAP  = 3'd4;
  localparam logic [2:0] S_DEC   = 3'd5;
  localparam logic [2:0] S_ADD   = 3'd6;
  localparam logic [2:0] S_SCALE = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] amt_r, amt_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [19:0] usec_r, usec_nxt;
  logic [31:0] now_r, now_nxt;
  logic [22:0] us7_r, us7_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] last_r, last_nxt;
  logic [63:0] total_r, total_nxt;
  logic [31:0] ps_r, ps_nxt;
  logic        fin_r, fin_nxt;
  logic        out_valid_r, out_valid_nxt;
  dcrm_out_t   out_r, out_nxt;

  // Shared add/subtract unit: y = a + (inv ? ~b : b) + cin
  logic [31:0] alu_a, alu_b, alu_y;
  logic        alu_inv, alu_cin;
  logic [2:0]  frac;
  logic        big_rate;
  logic        in_acc;

  assign alu_y    = alu_a + (alu_inv ? ~alu_b : alu_b) + {31'd0, alu_cin};
  assign big_rate = (rate_r > RATE_BIG);
  assign in_acc   = in_valid && in_ready;

  // Fractional tick: how many whole million-steps fit in usec*7
  always_comb begin
    frac = 3'd0;
    for (int k = 1; k <= TICKS_PER_SEC; k++) begin
      if (us7_r >= 23'(k) * US_PER_SECOND) frac = 3'(k);
    end
  end

  // Operand selection for the shared unit
  always_comb begin
    alu_a   = 32'd0;
    alu_b   = 32'd0;
    alu_inv = 1'b0;
    alu_cin = 1'b0;
    case (state_r)
      S_SEC7: begin
        alu_a   = {sec_r[28:0], 3'b000};
        alu_b   = sec_r;
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      S_US7: begin
        alu_a   = {9'd0, usec_r, 3'b000};
        alu_b   = {12'd0, usec_r};
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      S_NOW: begin
        alu_a = now_r;
        alu_b = {29'd0, frac};
      end
      S_ELAP: begin
        alu_a   = now_r;
        alu_b   = last_r;
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      S_DEC: begin
        // floor(7r/8) = r - (r>>3) - (low bits nonzero)
        alu_a   = rate_r;
        alu_b   = {3'b000, rate_r[31:3]};
        alu_inv = 1'b1;
        alu_cin = (rate_r[2:0] == 3'd0);
      end
      S_ADD: begin
        alu_a = rate_r;
        alu_b = amt_r;
      end
      S_SCALE: begin
        // big: (r>>3)*7 ; else ceil(7r/8) = r - (r>>3)
        alu_a   = big_rate ? {rate_r[31:3], 3'b000} : rate_r;
        alu_b   = {3'b000, rate_r[31:3]};
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      default: begin
        alu_a = 32'd0;
      end
    endcase
  end

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    amt_nxt       = amt_r;
    sec_nxt       = sec_r;
    usec_nxt      = usec_r;
    now_nxt       = now_r;
    us7_nxt       = us7_r;
    cnt_nxt       = cnt_r;
    rate_nxt      = rate_r;
    last_nxt      = last_r;
    total_nxt     = total_r;
    ps_nxt        = ps_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    // Output register drains independently
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          amt_nxt   = (in_data.kind == KIND_READ) ? 32'd0 : in_data.amount;
          sec_nxt   = in_data.seconds;
          usec_nxt  = in_data.microseconds;
          state_nxt = S_SEC7;
        end
      end
      S_SEC7: begin
        now_nxt   = alu_y;
        state_nxt = S_US7;
      end
      S_US7: begin
        us7_nxt   = alu_y[22:0];
        state_nxt = S_NOW;
      end
      S_NOW: begin
        now_nxt   = alu_y;
        state_nxt = S_ELAP;
      end
      S_ELAP: begin
        last_nxt  = now_r;
        total_nxt = total_r + {32'd0, amt_r};
        cnt_nxt   = alu_y[7:0];
        if (alu_y > HISTORY_TICKS) begin
          rate_nxt  = amt_r;
          state_nxt = S_SCALE;
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (cnt_r == 8'd0 || rate_r == 32'd0) begin
          state_nxt = S_ADD;
        end else begin
          rate_nxt = alu_y;
          cnt_nxt  = cnt_r - 8'd1;
        end
      end
      S_ADD: begin
        rate_nxt  = alu_y;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        // first pass computes the scaled rate, then waits for a free slot
        if (!fin_r) begin
          ps_nxt  = alu_y;
          fin_nxt = 1'b1;
        end else if (!out_valid_r || out_ready) begin
          out_nxt.rate_per_second = ps_r;
          out_nxt.grand_total     = total_r;
          out_valid_nxt           = 1'b1;
          fin_nxt                 = 1'b0;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_r      <= 32'd0;
      last_r      <= 32'd0;
      total_r     <= 64'd0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rate_r      <= rate_nxt;
      last_r      <= last_nxt;
      total_r     <= total_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    amt_r  <= amt_nxt;
    sec_r  <= sec_nxt;
    usec_r <= usec_nxt;
    now_r  <= now_nxt;
    us7_r  <= us7_nxt;
    cnt_r  <= cnt_nxt;
    ps_r   <= ps_nxt;
    out_r  <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/dcrm_checker.sv */
// Port-level checks for the decaying rate meter, bound to the top level.
module dcrm_checker
  import dcrm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input dcrm_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input dcrm_out_t out_data
);

  // Output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  // One beat at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

  // No result appears the cycle after an accept
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind decaying_rate_meter dcrm_checker u_dcrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/decaying_rate_meter_test.sv */
// Self-checking testbench for the decaying rate meter: directed and random beats.
module decaying_rate_meter_test;
  import dcrm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int DRAIN_CYCLES = 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  dcrm_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  dcrm_out_t out_data;

  // Predictor state, mirrors the block after reset
  logic [63:0] meter_total = '0;
  logic [31:0] meter_rate = '0;
  logic [31:0] meter_last_tick = '0;

  dcrm_out_t   expected_results[$];
  logic [31:0] sender_tick = '0;
  int          send_idle_pct = 0;
  int          ready_stall_pct = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  decaying_rate_meter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Predict one result and advance the predictor state
  function automatic dcrm_out_t predict_meter(dcrm_in_t ev);
    logic [31:0] amt;
    logic [31:0] now_tick;
    logic [31:0] frac_tick;
    logic [31:0] elapsed;
    logic [31:0] r;
    logic [32:0] w;
    dcrm_out_t   res;
    amt = (ev.kind == KIND_READ) ? 32'd0 : ev.amount;
    frac_tick = ({12'd0, ev.microseconds} * 32'd7) / 32'd1000000;
    now_tick = ev.seconds * 32'd7 + frac_tick;
    elapsed = now_tick - meter_last_tick;
    meter_total = meter_total + {32'd0, amt};
    if (elapsed > HISTORY_TICKS) begin
      meter_rate = amt;
    end else begin
      r = meter_rate;
      for (int i = 0; i < 167; i++) begin
        if (i < elapsed && r != 0) begin
          // one 7/8 step, computed wide so large rates do not wrap
          w = {1'b0, r};
          r = 32'(w - (w + 33'd7) / 33'd8);
        end
      end
      meter_rate = r + amt;
    end
    meter_last_tick = now_tick;
    if (meter_rate > RATE_BIG)
      res.rate_per_second = (meter_rate / 32'd8) * 32'd7;
    else
      res.rate_per_second = (meter_rate * 32'd7 + 32'd7) / 32'd8;
    res.grand_total = meter_total;
    return res;
  endfunction

  // Build an event at a given tick, microseconds random within that tick
  function automatic dcrm_in_t meter_event(logic kind, logic [31:0] amount,
                                           logic [31:0] tick);
    dcrm_in_t    ev;
    logic [31:0] k;
    logic [31:0] lo;
    logic [31:0] hi;
    k = tick % 32'd7;
    lo = (k * 32'd1000000 + 32'd6) / 32'd7;
    hi = ((k + 32'd1) * 32'd1000000 + 32'd6) / 32'd7 - 32'd1;
    ev.kind = kind;
    ev.amount = amount;
    ev.seconds = tick / 32'd7;
    ev.microseconds = 20'($urandom_range(hi, lo));
    return ev;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Drive one beat at the falling edge, hold until accepted
  task automatic send_event(dcrm_in_t ev);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(predict_meter(ev));
  endtask

  task automatic send_at(logic kind, logic [31:0] amount, logic [31:0] tick);
    sender_tick = tick;
    send_event(meter_event(kind, amount, tick));
  endtask

  task automatic send_stamp(logic kind, logic [31:0] amount, logic [31:0] sec,
                            logic [19:0] usec);
    dcrm_in_t ev;
    ev.kind = kind;
    ev.amount = amount;
    ev.seconds = sec;
    ev.microseconds = usec;
    send_event(ev);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= ready_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    dcrm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.grand_total, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.rate_per_second !== want.rate_per_second)
          report_mismatch("rate_per_second", {32'd0, out_data.rate_per_second},
                          {32'd0, want.rate_per_second});
        if (out_data.grand_total !== want.grand_total)
          report_mismatch("grand_total", out_data.grand_total, want.grand_total);
      end
    end
  end

  // Full-scale amounts: rate wrap and big-rate decay and scaling
  task automatic test_extremes();
    send_at(KIND_COUNT, 32'hFFFF_FFFF, 32'd0);
    send_at(KIND_COUNT, 32'hFFFF_FFFF, 32'd0);
    send_at(KIND_COUNT, 32'd0, 32'd1);
    send_at(KIND_COUNT, 32'd0, 32'd1);
    send_at(KIND_COUNT, 32'd1, 32'd2);
  endtask

  // Read beats ignore the amount
  task automatic test_read_items();
    send_at(KIND_READ, 32'hFFFF_FFFF, 32'd3);
    send_at(KIND_READ, 32'hA5A5_5A5A, 32'd10);
    send_at(KIND_COUNT, 32'd1, 32'd10);
  endtask

  // Odd time stamps: oversize microseconds, tick wrap, time going backwards
  task automatic test_time_stamps();
    send_stamp(KIND_COUNT, 32'd5000, 32'd2, 20'hFFFFF);
    send_stamp(KIND_COUNT, 32'd700, 32'hFFFF_FFFF, 20'd999999);
    send_stamp(KIND_COUNT, 32'd300, 32'd0, 20'd0);
    send_stamp(KIND_COUNT, 32'd12345, 32'd1000, 20'd0);
    send_stamp(KIND_COUNT, 32'd99, 32'd999, 20'd500000);
    send_stamp(KIND_READ, 32'd0, 32'h8000_0000, 20'h80000);
  endtask

  // Edges of the 166-tick history window and of the scaling split
  task automatic test_history_window();
    logic [31:0] t0;
    t0 = 32'd5000;
    send_at(KIND_COUNT, 32'hFFFF_FFFF, t0);
    send_at(KIND_COUNT, 32'd800, t0 + 32'd166);
    send_at(KIND_COUNT, 32'h0FFF_FFFF, t0 + 32'd333);
    send_at(KIND_COUNT, 32'd1, t0 + 32'd333);
    send_at(KIND_COUNT, 32'd1000, t0 + 32'd334);
    send_at(KIND_COUNT, 32'd7, t0 + 32'd500);
  endtask

  // Random traffic: mostly advancing time stamps, some noise beats
  task automatic test_random_traffic(int beats, int idle_pct, int stall_pct);
    logic [31:0] amount;
    logic [31:0] delta;
    logic        kind;
    dcrm_in_t    ev;
    send_idle_pct = idle_pct;
    ready_stall_pct = stall_pct;
    for (int n = 0; n < beats; n++) begin
      case ($urandom_range(3, 0))
        0: amount = $urandom_range(255, 0);
        1: amount = $urandom;
        2: amount = 32'hFFFF_FFFF - $urandom_range(255, 0);
        default: amount = $urandom_range(32'h1FFF_FFFF, 0);
      endcase
      kind = ($urandom_range(4, 0) == 0) ? KIND_READ : KIND_COUNT;
      if ($urandom_range(99, 0) < 85) begin
        case ($urandom_range(9, 0))
          0, 1, 2, 3: delta = $urandom_range(7, 0);
          4, 5, 6:    delta = $urandom_range(166, 0);
          7:          delta = $urandom_range(169, 164);
          8:          delta = $urandom;
          default:    delta = 32'd0;
        endcase
        send_at(kind, amount, sender_tick + delta);
      end else begin
        ev.kind = kind;
        ev.amount = amount;
        ev.seconds = $urandom;
        ev.microseconds = 20'($urandom_range(20'hFFFFF, 0));
        send_event(ev);
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_read_items();
    test_time_stamps();
    test_history_window();

    sender_tick = $urandom;
    test_random_traffic(240, 0, 0);
    test_random_traffic(240, 83, 0);
    test_random_traffic(240, 0, 83);
    test_random_traffic(240, 32, 32);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
